@@ src/ucsp_pkg.sv @@
// Shared types and constants for the command-driven four-channel servo PWM block.
package ucsp_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_TICKS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_PERIODS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_NEUTRAL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_LOW        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_HIGH       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_OFF      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_ON       = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_PERIOD_TICKS    = 16'd2000;
    localparam logic [7:0]  RST_TIMEOUT_PERIODS = 8'd200;
    localparam logic [7:0]  RST_AXIS_NEUTRAL    = 8'd150;
    localparam logic [7:0]  RST_AXIS_LOW        = 8'd140;
    localparam logic [7:0]  RST_AXIS_HIGH       = 8'd160;
    localparam logic [7:0]  RST_SWITCH_OFF      = 8'd100;
    localparam logic [7:0]  RST_SWITCH_ON       = 8'd220;

    // Item kinds.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Switch command bytes ('a' and 'b').
    localparam logic [7:0] CMD_SWITCH3 = 8'h61;
    localparam logic [7:0] CMD_SWITCH4 = 8'h62;

    typedef enum logic [1:0] {
        AXIS_NEUTRAL,
        AXIS_LOW,
        AXIS_HIGH
    } axis_sel_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] cmd_byte;
    } ucsp_in_t;

    typedef struct packed {
        logic pin_ch1;
        logic pin_ch2;
        logic pin_ch3;
        logic pin_ch4;
    } ucsp_out_t;

    typedef struct packed {
        logic [15:0] period_ticks;
        logic [7:0]  timeout_periods;
        logic [7:0]  axis_neutral;
        logic [7:0]  axis_low;
        logic [7:0]  axis_high;
        logic [7:0]  switch_off;
        logic [7:0]  switch_on;
    } ucsp_cfg_t;

endpackage

@@ src/ucsp_core.sv @@
// Frame counter, timeout and channel width state with the four pulse comparators.
module ucsp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  ucsp_pkg::ucsp_in_t  item,
    input  ucsp_pkg::ucsp_cfg_t cfg,
    output ucsp_pkg::ucsp_out_t pins
);

    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  frame_count_reg, frame_count_next;
    logic [7:0]  width_ch1_reg, width_ch1_next;
    logic [7:0]  width_ch2_reg, width_ch2_next;
    logic [7:0]  width_ch3_reg, width_ch3_next;
    logic [7:0]  width_ch4_reg, width_ch4_next;

    logic [15:0] tick_inc;
    logic        frame_wrap;
    logic [7:0]  frame_inc;
    logic        timed_out;
    ucsp_pkg::axis_sel_t sel_ch1, sel_ch2;

    function automatic logic [7:0] axis_width(ucsp_pkg::axis_sel_t sel,
                                              ucsp_pkg::ucsp_cfg_t c);
        logic [7:0] w;
        case (sel)
            ucsp_pkg::AXIS_LOW:  w = c.axis_low;
            ucsp_pkg::AXIS_HIGH: w = c.axis_high;
            default:             w = c.axis_neutral;
        endcase
        return w;
    endfunction

    // Codes 1 to 9 form a 3x3 grid: channel one walks the column, channel two the row.
    always_comb
    begin
        case (item.cmd_byte)
            8'd1:    begin sel_ch1 = ucsp_pkg::AXIS_NEUTRAL; sel_ch2 = ucsp_pkg::AXIS_NEUTRAL; end
            8'd2:    begin sel_ch1 = ucsp_pkg::AXIS_LOW;     sel_ch2 = ucsp_pkg::AXIS_NEUTRAL; end
            8'd3:    begin sel_ch1 = ucsp_pkg::AXIS_HIGH;    sel_ch2 = ucsp_pkg::AXIS_NEUTRAL; end
            8'd4:    begin sel_ch1 = ucsp_pkg::AXIS_NEUTRAL; sel_ch2 = ucsp_pkg::AXIS_LOW;     end
            8'd5:    begin sel_ch1 = ucsp_pkg::AXIS_LOW;     sel_ch2 = ucsp_pkg::AXIS_LOW;     end
            8'd6:    begin sel_ch1 = ucsp_pkg::AXIS_HIGH;    sel_ch2 = ucsp_pkg::AXIS_LOW;     end
            8'd7:    begin sel_ch1 = ucsp_pkg::AXIS_NEUTRAL; sel_ch2 = ucsp_pkg::AXIS_HIGH;    end
            8'd8:    begin sel_ch1 = ucsp_pkg::AXIS_LOW;     sel_ch2 = ucsp_pkg::AXIS_HIGH;    end
            8'd9:    begin sel_ch1 = ucsp_pkg::AXIS_HIGH;    sel_ch2 = ucsp_pkg::AXIS_HIGH;    end
            default: begin sel_ch1 = ucsp_pkg::AXIS_NEUTRAL; sel_ch2 = ucsp_pkg::AXIS_NEUTRAL; end
        endcase
    end

    assign tick_inc   = tick_count_reg + 16'd1;
    assign frame_wrap = (tick_inc >= cfg.period_ticks);
    assign frame_inc  = frame_wrap ? (frame_count_reg + 8'd1) : frame_count_reg;
    assign timed_out  = (frame_inc >= cfg.timeout_periods);

    always_comb
    begin
        tick_count_next  = tick_count_reg;
        frame_count_next = frame_count_reg;
        width_ch1_next   = width_ch1_reg;
        width_ch2_next   = width_ch2_reg;
        width_ch3_next   = width_ch3_reg;
        width_ch4_next   = width_ch4_reg;
        if (step)
        begin
            if (item.kind == ucsp_pkg::KIND_CMD)
            begin
                frame_count_next = 8'd0;
                width_ch1_next   = axis_width(sel_ch1, cfg);
                width_ch2_next   = axis_width(sel_ch2, cfg);
                width_ch3_next   = (item.cmd_byte == ucsp_pkg::CMD_SWITCH3) ?
                                   cfg.switch_on : cfg.switch_off;
                width_ch4_next   = (item.cmd_byte == ucsp_pkg::CMD_SWITCH4) ?
                                   cfg.switch_on : cfg.switch_off;
            end
            else
            begin
                tick_count_next  = frame_wrap ? 16'd0 : tick_inc;
                frame_count_next = timed_out ? 8'd0 : frame_inc;
                if (timed_out)
                begin
                    width_ch1_next = cfg.axis_neutral;
                    width_ch2_next = cfg.axis_neutral;
                    width_ch3_next = cfg.switch_off;
                    width_ch4_next = cfg.switch_off;
                end
            end
        end
    end

    // Pins compare the updated counter against the updated widths.
    assign pins.pin_ch1 = (tick_count_next < {8'd0, width_ch1_next});
    assign pins.pin_ch2 = (tick_count_next < {8'd0, width_ch2_next});
    assign pins.pin_ch3 = (tick_count_next < {8'd0, width_ch3_next});
    assign pins.pin_ch4 = (tick_count_next < {8'd0, width_ch4_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= 16'd0;
            frame_count_reg <= 8'd0;
            width_ch1_reg   <= ucsp_pkg::RST_AXIS_NEUTRAL;
            width_ch2_reg   <= ucsp_pkg::RST_AXIS_NEUTRAL;
            width_ch3_reg   <= ucsp_pkg::RST_SWITCH_OFF;
            width_ch4_reg   <= ucsp_pkg::RST_SWITCH_OFF;
        end
        else
        begin
            tick_count_reg  <= tick_count_next;
            frame_count_reg <= frame_count_next;
            width_ch1_reg   <= width_ch1_next;
            width_ch2_reg   <= width_ch2_next;
            width_ch3_reg   <= width_ch3_next;
            width_ch4_reg   <= width_ch4_next;
        end
    end

endmodule

@@ src/uart_command_servo_pwm.sv @@
// Top level of the command-driven four-channel servo PWM block.
//
// The block takes one item per clock cycle while in_stall is low, ticks and
// command bytes alike. An accepted item is held in an input register. From
// there a single pass of logic updates the tick and frame counters or loads
// new channel widths, and for a tick writes the four pin levels into the
// output register, which offers them as the result; a command byte updates
// the state and produces no result. The output register is the only place a
// result waits, so input stall rises only while a tick sits in the input
// register and the output register is full and stalled. Configuration
// writes are always ready and take effect on the next item; write them only
// while no item is in flight. Writes to an index past the last register are
// ignored.
module uart_command_servo_pwm (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  ucsp_pkg::ucsp_in_t                 in_data,
    output logic                               in_stall,
    output logic                               out_valid,
    output ucsp_pkg::ucsp_out_t                out_data,
    input  logic                               out_stall,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ucsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ucsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ucsp_pkg::ucsp_cfg_t cfg_reg;
    logic                s1_valid_reg;
    ucsp_pkg::ucsp_in_t  s1_item_reg;
    logic                out_valid_reg;
    ucsp_pkg::ucsp_out_t out_data_reg;
    ucsp_pkg::ucsp_out_t pins;
    logic                out_free;
    logic                s1_step;
    logic                s1_is_tick;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks    <= ucsp_pkg::RST_PERIOD_TICKS;
            cfg_reg.timeout_periods <= ucsp_pkg::RST_TIMEOUT_PERIODS;
            cfg_reg.axis_neutral    <= ucsp_pkg::RST_AXIS_NEUTRAL;
            cfg_reg.axis_low        <= ucsp_pkg::RST_AXIS_LOW;
            cfg_reg.axis_high       <= ucsp_pkg::RST_AXIS_HIGH;
            cfg_reg.switch_off      <= ucsp_pkg::RST_SWITCH_OFF;
            cfg_reg.switch_on       <= ucsp_pkg::RST_SWITCH_ON;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ucsp_pkg::REG_PERIOD_TICKS:    cfg_reg.period_ticks    <= cfg_data;
                ucsp_pkg::REG_TIMEOUT_PERIODS: cfg_reg.timeout_periods <= cfg_data[7:0];
                ucsp_pkg::REG_AXIS_NEUTRAL:    cfg_reg.axis_neutral    <= cfg_data[7:0];
                ucsp_pkg::REG_AXIS_LOW:        cfg_reg.axis_low        <= cfg_data[7:0];
                ucsp_pkg::REG_AXIS_HIGH:       cfg_reg.axis_high       <= cfg_data[7:0];
                ucsp_pkg::REG_SWITCH_OFF:      cfg_reg.switch_off      <= cfg_data[7:0];
                ucsp_pkg::REG_SWITCH_ON:       cfg_reg.switch_on       <= cfg_data[7:0];
                default:                       ;
            endcase
        end
    end

    // The input register item is processed when it has somewhere to go. A
    // command never needs the output register; a tick needs it empty or
    // draining in this cycle.
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_is_tick = (s1_item_reg.kind == ucsp_pkg::KIND_TICK);
    assign s1_step    = s1_valid_reg && (!s1_is_tick || out_free);
    assign in_stall   = s1_valid_reg && !s1_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_item_reg <= in_data;
        end
    end

    ucsp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_step),
        .item  (s1_item_reg),
        .cfg   (cfg_reg),
        .pins  (pins)
    );

    // Output register: loaded by a processed tick, cleared once its transfer
    // completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_step && s1_is_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_step && s1_is_tick)
        begin
            out_data_reg <= pins;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A stall can only come from a tick waiting on a full output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_is_tick && out_valid_reg && out_stall))
        else $error("input stall without a blocked tick");

    // A processed tick always yields a result in the next cycle.
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_step && s1_is_tick) |=> out_valid_reg)
        else $error("processed tick produced no result");

    // A command never lands in the output register.
    a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_step && !s1_is_tick && !out_valid_reg) |=> !out_valid_reg)
        else $error("command produced a result");

    // A held item is not overwritten while stalled.
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stalled input register item changed");

endmodule

@@ sim/ucsp_tb_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the pin levels of the servo PWM block.
package ucsp_tb_pkg;
    import ucsp_pkg::*;

    // Command bytes that select one of the nine axis positions.
    localparam logic [7:0] CMD_AXIS_FIRST = 8'd1;
    localparam logic [7:0] CMD_AXIS_LAST  = 8'd9;

    class servo_pin_scoreboard;
        ucsp_cfg_t   regs;
        logic [15:0] tick_count;
        logic [7:0]  frame_count;
        logic [7:0]  width_ch [4];
        ucsp_out_t   pending_levels [$];
        int unsigned fail_count;
        int unsigned result_count;

        function new();
            regs.period_ticks    = RST_PERIOD_TICKS;
            regs.timeout_periods = RST_TIMEOUT_PERIODS;
            regs.axis_neutral    = RST_AXIS_NEUTRAL;
            regs.axis_low        = RST_AXIS_LOW;
            regs.axis_high       = RST_AXIS_HIGH;
            regs.switch_off      = RST_SWITCH_OFF;
            regs.switch_on       = RST_SWITCH_ON;
            tick_count   = '0;
            frame_count  = '0;
            fail_count   = 0;
            result_count = 0;
            center_all();
        endfunction

        function void center_all();
            width_ch[0] = regs.axis_neutral;
            width_ch[1] = regs.axis_neutral;
            width_ch[2] = regs.switch_off;
            width_ch[3] = regs.switch_off;
        endfunction

        function logic [7:0] axis_width(axis_sel_t sel);
            case (sel)
                AXIS_LOW:  return regs.axis_low;
                AXIS_HIGH: return regs.axis_high;
                default:   return regs.axis_neutral;
            endcase
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_PERIOD_TICKS:    regs.period_ticks    = data;
                REG_TIMEOUT_PERIODS: regs.timeout_periods = data[7:0];
                REG_AXIS_NEUTRAL:    regs.axis_neutral    = data[7:0];
                REG_AXIS_LOW:        regs.axis_low        = data[7:0];
                REG_AXIS_HIGH:       regs.axis_high       = data[7:0];
                REG_SWITCH_OFF:      regs.switch_off      = data[7:0];
                REG_SWITCH_ON:       regs.switch_on       = data[7:0];
                default: ;
            endcase
        endfunction

        // Advances the predicted state by one accepted item; a tick queues its pin levels.
        function void take_item(ucsp_in_t item);
            ucsp_out_t   levels;
            int unsigned sel;
            if (item.kind == KIND_CMD)
            begin
                frame_count = '0;
                center_all();
                if (item.cmd_byte >= CMD_AXIS_FIRST && item.cmd_byte <= CMD_AXIS_LAST)
                begin
                    sel = 32'(item.cmd_byte - CMD_AXIS_FIRST);
                    width_ch[0] = axis_width(axis_sel_t'(sel % 3));
                    width_ch[1] = axis_width(axis_sel_t'(sel / 3));
                end
                else if (item.cmd_byte == CMD_SWITCH3)
                begin
                    width_ch[2] = regs.switch_on;
                end
                else if (item.cmd_byte == CMD_SWITCH4)
                begin
                    width_ch[3] = regs.switch_on;
                end
            end
            else
            begin
                tick_count = tick_count + 16'd1;
                if (tick_count >= regs.period_ticks)
                begin
                    tick_count  = '0;
                    frame_count = frame_count + 8'd1;
                end
                if (frame_count >= regs.timeout_periods)
                begin
                    frame_count = '0;
                    center_all();
                end
                levels.pin_ch1 = tick_count < 16'(width_ch[0]);
                levels.pin_ch2 = tick_count < 16'(width_ch[1]);
                levels.pin_ch3 = tick_count < 16'(width_ch[2]);
                levels.pin_ch4 = tick_count < 16'(width_ch[3]);
                pending_levels.push_back(levels);
            end
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_levels(ucsp_out_t got);
            ucsp_out_t want;
            result_count++;
            if (pending_levels.size() == 0)
            begin
                flag($sformatf("result %0d (pins %b) arrived with nothing expected",
                               result_count, got));
                return;
            end
            want = pending_levels.pop_front();
            if (got.pin_ch1 !== want.pin_ch1 || got.pin_ch2 !== want.pin_ch2 ||
                got.pin_ch3 !== want.pin_ch3 || got.pin_ch4 !== want.pin_ch4)
                flag($sformatf("result %0d: expected pins ch1..ch4 %b, got %b",
                               result_count, want, got));
        endfunction

        function int unsigned pending();
            return pending_levels.size();
        endfunction
    endclass

endpackage

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench top that runs ticks and command bytes through the servo PWM block and checks pins.
module tb;
    import ucsp_pkg::*;
    import ucsp_tb_pkg::*;

    // Length of the long receiver hold-off that fills the block and backs up its input.
    localparam int unsigned HOLD_CYCLES = 70;
    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned PHASE_ITEMS = 52;
    // An index past the last register; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = REG_SWITCH_ON + 1'b1;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    ucsp_in_t               in_data;
    logic                   in_stall;
    logic                   out_valid;
    ucsp_out_t              out_data;
    logic                   out_stall;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Traffic shaping flags that the main sequence sets for the sender and the receiver.
    bit          send_gaps;
    bit          recv_gaps;
    bit          hold_off;
    int unsigned cmd_pct;
    int unsigned quiet_cycles;

    servo_pin_scoreboard sb;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    uart_command_servo_pwm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Every result transfer is checked against the oldest predicted pin levels.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_levels(out_data);
    end

    // The watchdog restarts its count on any transfer on any of the three channels.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    // The receiver stalls in random bursts, or for one long stretch when the main
    // sequence asks for back-pressure. Stall only changes at the falling edge.
    initial
    begin
        int unsigned span;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if (recv_gaps && $urandom_range(0, 99) < 8)
            begin
                span = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (span) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic ucsp_in_t make_in(logic kind, logic [7:0] code);
        ucsp_in_t item;
        item.kind     = kind;
        item.cmd_byte = code;
        return item;
    endfunction

    // Mostly ticks; commands favor the nine axis codes and the two switch codes,
    // with the rest spread over the whole byte range.
    function automatic ucsp_in_t random_item();
        ucsp_in_t    item;
        int unsigned roll;
        item.kind     = KIND_TICK;
        item.cmd_byte = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < cmd_pct)
        begin
            item.kind = KIND_CMD;
            roll = $urandom_range(0, 99);
            if (roll < 50)
                item.cmd_byte = 8'($urandom_range(CMD_AXIS_FIRST, CMD_AXIS_LAST));
            else if (roll < 75)
                item.cmd_byte = ($urandom_range(0, 1) != 0) ? CMD_SWITCH3 : CMD_SWITCH4;
        end
        return item;
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4:    return 16'($urandom_range(2, 12));
            default: return 16'($urandom_range(13, 300));
        endcase
    endfunction

    function automatic logic [7:0] pick_timeout();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd1;
            default: return 8'($urandom_range(2, 6));
        endcase
    endfunction

    function automatic logic [7:0] pick_width();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Upper byte for an 8-bit register write; the block must drop it.
    function automatic logic [7:0] upper_byte(bit dirty);
        return dirty ? 8'($urandom_range(0, 255)) : 8'd0;
    endfunction

    // Offers one item, with an optional random gap before it, and holds it until
    // the block takes it. Valid stays high between back-to-back items.
    task automatic push_item(input ucsp_in_t item);
        int unsigned gap;
        @(negedge clk);
        if (send_gaps && $urandom_range(0, 99) < 12)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.take_item(item);
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) push_item(random_item());
    endtask

    // Drops valid, lets every predicted result come out, then leaves a few cycles
    // for a trailing command, which has no result, to settle inside the block.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setting(input logic [15:0] period, input logic [7:0] timeout,
                                input logic [7:0] w_neutral, input logic [7:0] w_low,
                                input logic [7:0] w_high, input logic [7:0] w_off,
                                input logic [7:0] w_on, input bit dirty);
        write_reg(REG_PERIOD_TICKS, period);
        write_reg(REG_TIMEOUT_PERIODS, {upper_byte(dirty), timeout});
        write_reg(REG_AXIS_NEUTRAL, {upper_byte(dirty), w_neutral});
        write_reg(REG_AXIS_LOW, {upper_byte(dirty), w_low});
        write_reg(REG_AXIS_HIGH, {upper_byte(dirty), w_high});
        write_reg(REG_SWITCH_OFF, {upper_byte(dirty), w_off});
        write_reg(REG_SWITCH_ON, {upper_byte(dirty), w_on});
    endtask

    // Every axis code and both switch codes, each followed by a tick so the new
    // widths show up on the pins, then three bytes outside the command set and a tick.
    task automatic directed_items();
        push_item(make_in(KIND_TICK, 8'hFF));
        for (int code = CMD_AXIS_FIRST; code <= CMD_AXIS_LAST; code++)
        begin
            push_item(make_in(KIND_CMD, 8'(code)));
            push_item(make_in(KIND_TICK, 8'h00));
        end
        push_item(make_in(KIND_CMD, CMD_SWITCH3));
        push_item(make_in(KIND_TICK, 8'h00));
        push_item(make_in(KIND_CMD, CMD_SWITCH4));
        push_item(make_in(KIND_TICK, 8'h00));
        // Zero, the first byte past the axis codes and all ones all mean neutral.
        push_item(make_in(KIND_CMD, 8'h00));
        push_item(make_in(KIND_CMD, 8'd10));
        push_item(make_in(KIND_CMD, 8'hFF));
        push_item(make_in(KIND_TICK, 8'hFF));
    endtask

    initial
    begin
        sb = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        send_gaps    = 1'b1;
        recv_gaps    = 1'b1;
        hold_off     = 1'b0;
        cmd_pct      = 20;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first phase runs on the reset values of all registers.
        directed_items();
        send_random(PHASE_ITEMS);
        settle();

        // A one-tick frame with a one-frame timeout and all widths at zero: the
        // counter wraps every tick and the widths revert on every tick.
        load_setting(16'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_random(PHASE_ITEMS);
        settle();

        // Zero period and zero timeout with full widths, garbage in the upper
        // data byte, and a write to an index that does not exist.
        load_setting(16'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
        send_random(PHASE_ITEMS);
        settle();

        // The longest frame and timeout; the counter never wraps in this phase,
        // so the next phase usually lowers the period below the counter.
        load_setting(16'hFFFF, 8'hFF, pick_width(), pick_width(), pick_width(),
                     pick_width(), pick_width(), 1'b1);
        cmd_pct = 5;
        send_random(PHASE_ITEMS);
        settle();

        for (int p = 0; p < 5; p++)
        begin
            load_setting(pick_period(), pick_timeout(), pick_width(), pick_width(),
                         pick_width(), pick_width(), pick_width(), 1'b1);
            cmd_pct = $urandom_range(3, 25);
            if (p == 1)
            begin
                // Back-pressure: the receiver holds off while items keep coming.
                send_gaps = 1'b0;
                hold_off  = 1'b1;
            end
            if (p == 4)
            begin
                // The closing phase runs at full rate on both sides.
                send_gaps = 1'b0;
                recv_gaps = 1'b0;
            end
            send_random(PHASE_ITEMS);
            send_gaps = (p < 3);
            settle();
        end

        repeat (8) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
